### rtl/core/hts_pkg.sv
// hts_pkg: shared types, constants and entity tables for the html tag stripper
// used by every module under rtl/core; depends on nothing

package hts_pkg;

  localparam int unsigned MaxOut       = 6;
  localparam int unsigned NumEnt       = 4;
  localparam int unsigned HeldDepth    = 4;
  localparam int unsigned QueueDepthDf = 4;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChQuot = 8'h22;
  localparam logic [7:0] ChSemi = 8'h3B;

  typedef enum logic [1:0] {
    EntAmp  = 2'd0,
    EntLt   = 2'd1,
    EntGt   = 2'd2,
    EntQuot = 2'd3
  } ent_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;
  } out_beat_t;

  // results caused by one input beat
  typedef struct packed {
    logic [MaxOut-1:0][7:0] data;
    logic [2:0]             count;
    logic                   fin;
  } burst_t;

  function automatic logic [2:0] ent_len(input ent_e e);
    logic [2:0] len;
    unique case (e)
      EntAmp:  len = 3'd5;
      EntLt:   len = 3'd4;
      EntGt:   len = 3'd4;
      EntQuot: len = 3'd6;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] ent_sym(input ent_e e);
    logic [7:0] sym;
    unique case (e)
      EntAmp:  sym = ChAmp;
      EntLt:   sym = ChLt;
      EntGt:   sym = ChGt;
      EntQuot: sym = ChQuot;
      default: sym = 8'h00;
    endcase
    return sym;
  endfunction

  // character at position pos of the entity text, position 0 being the ampersand (not returned: pos 0 gives 8'h00)
  function automatic logic [7:0] ent_chr(input ent_e e, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (e)
      EntAmp: begin
        unique case (pos)
          3'd1:    ch = 8'h61;
          3'd2:    ch = 8'h6D;
          3'd3:    ch = 8'h70;
          3'd4:    ch = ChSemi;
          default: ch = 8'h00;
        endcase
      end
      EntLt: begin
        unique case (pos)
          3'd1:    ch = 8'h6C;
          3'd2:    ch = 8'h74;
          3'd3:    ch = ChSemi;
          default: ch = 8'h00;
        endcase
      end
      EntGt: begin
        unique case (pos)
          3'd1:    ch = 8'h67;
          3'd2:    ch = 8'h74;
          3'd3:    ch = ChSemi;
          default: ch = 8'h00;
        endcase
      end
      EntQuot: begin
        unique case (pos)
          3'd1:    ch = 8'h71;
          3'd2:    ch = 8'h75;
          3'd3:    ch = 8'h6F;
          3'd4:    ch = 8'h74;
          3'd5:    ch = ChSemi;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

### rtl/core/html_tag_strip_entity_decode.sv
// Strips html tags and decodes &amp; &lt; &gt; &quot; on a byte stream. One input beat
// is taken per cycle while the burst queue has room; a beat causes 0 to 6 result beats
// (a final beat with no text gives one empty end marker), and the back end sends one
// result beat per cycle while the receiver does not stall; the queue of QueueDepth
// bursts absorbs the expansion.
// Depends on hts_pkg, hts_front, hts_queue and hts_back.

module html_tag_strip_entity_decode #(
  parameter int unsigned QueueDepth = hts_pkg::QueueDepthDf
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hts_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hts_pkg::out_beat_t out_data_o
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            q_valid;
  logic            q_full;
  hts_pkg::burst_t burst_in;
  hts_pkg::burst_t burst_head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  hts_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .burst_o   (burst_in)
  );

  hts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (burst_in),
    .pop_i   (pop),
    .rdata_o (burst_head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  hts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (burst_head),
    .head_valid_i (q_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

### rtl/core/hts_front.sv
// hts_front: tag tracking and entity matching, one input beat per cycle while accept_i is high
// builds the burst of results per beat; depends on hts_pkg

module hts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  hts_pkg::in_beat_t in_data_i,
  output logic              push_o,
  output hts_pkg::burst_t   burst_o
);

  logic       tag_q, tag_d;
  logic [2:0] ml_q, ml_d;
  logic [3:0] mask_q, mask_d;
  logic [7:0] held_q [hts_pkg::HeldDepth];
  logic [7:0] held_d [hts_pkg::HeldDepth];

  logic [hts_pkg::MaxOut-1:0][7:0] buf_c;
  logic [2:0] n_c;
  logic [3:0] keep_c;
  logic       done_c;
  logic       plain_c;
  logic [7:0] ch_c;
  logic       fin_c;

  always_comb begin
    ch_c    = in_data_i.in_byte;
    fin_c   = in_data_i.is_final;
    tag_d   = tag_q;
    ml_d    = ml_q;
    mask_d  = mask_q;
    held_d  = held_q;
    buf_c   = '0;
    n_c     = '0;
    keep_c  = '0;
    done_c  = 1'b0;
    plain_c = 1'b1;

    if (ml_q != 3'd0) begin
      for (int e = 0; e < hts_pkg::NumEnt; e++) begin
        keep_c[e] = mask_q[e] && (ml_q < hts_pkg::ent_len(hts_pkg::ent_e'(e)))
                    && (hts_pkg::ent_chr(hts_pkg::ent_e'(e), ml_q) == ch_c);
      end
      if (keep_c != 4'd0) begin
        plain_c = 1'b0;
        for (int e = 0; e < hts_pkg::NumEnt; e++) begin
          if (!done_c && keep_c[e]
              && (3'(ml_q + 3'd1) == hts_pkg::ent_len(hts_pkg::ent_e'(e)))) begin
            buf_c[n_c] = hts_pkg::ent_sym(hts_pkg::ent_e'(e));
            n_c        = 3'(n_c + 3'd1);
            done_c     = 1'b1;
          end
        end
        if (done_c) begin
          ml_d   = 3'd0;
          mask_d = 4'd0;
        end else begin
          if (ml_q <= 3'd4) begin
            held_d[2'(ml_q - 3'd1)] = ch_c;
          end
          ml_d   = 3'(ml_q + 3'd1);
          mask_d = keep_c;
        end
      end else begin
        // mismatch: ampersand and held letters go out literally
        for (int k = 0; k <= hts_pkg::HeldDepth; k++) begin
          if (3'(k) < ml_q) begin
            buf_c[n_c] = (k == 0) ? hts_pkg::ChAmp : held_q[k-1];
            n_c        = 3'(n_c + 3'd1);
          end
        end
        ml_d   = 3'd0;
        mask_d = 4'd0;
      end
    end

    if (plain_c) begin
      priority if (ch_c == hts_pkg::ChLt) begin
        tag_d = 1'b1;
      end else if (ch_c == hts_pkg::ChGt) begin
        tag_d = 1'b0;
      end else if (tag_q) begin
        tag_d = 1'b1;
      end else if (ch_c == hts_pkg::ChAmp) begin
        ml_d   = 3'd1;
        mask_d = 4'hF;
      end else begin
        if (n_c < 3'(hts_pkg::MaxOut)) begin
          buf_c[n_c] = ch_c;
          n_c        = 3'(n_c + 3'd1);
        end
      end
    end

    if (fin_c) begin
      // end of text: pending partial entity goes out literally
      for (int k = 0; k <= hts_pkg::HeldDepth; k++) begin
        if (3'(k) < ml_d && n_c < 3'(hts_pkg::MaxOut)) begin
          buf_c[n_c] = (k == 0) ? hts_pkg::ChAmp : held_d[k-1];
          n_c        = 3'(n_c + 3'd1);
        end
      end
      tag_d  = 1'b0;
      ml_d   = 3'd0;
      mask_d = 4'd0;
    end
  end

  assign burst_o.data  = buf_c;
  assign burst_o.count = n_c;
  assign burst_o.fin   = fin_c;
  assign push_o        = accept_i && ((n_c != 3'd0) || fin_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= 1'b0;
      ml_q   <= 3'd0;
      mask_q <= 4'd0;
    end else if (accept_i) begin
      tag_q  <= tag_d;
      ml_q   <= ml_d;
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

### rtl/core/hts_queue.sv
// hts_queue: short register fifo of result bursts between front and back
// depends on hts_pkg for the burst type

module hts_queue #(
  parameter int unsigned Depth = hts_pkg::QueueDepthDf
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hts_pkg::burst_t wdata_i,
  input  logic            pop_i,
  output hts_pkg::burst_t rdata_o,
  output logic            valid_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hts_pkg::burst_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_pop;

  assign do_pop  = pop_i && valid_o;
  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CntW'(Depth);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_q + 1'b1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_q + 1'b1);
      end
      unique case ({push_i, do_pop})
        2'b10:   cnt_q <= CntW'(cnt_q + 1'b1);
        2'b01:   cnt_q <= CntW'(cnt_q - 1'b1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

### rtl/core/hts_back.sv
// hts_back: serializes queued bursts into result beats through an output register
// depends on hts_pkg

module hts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hts_pkg::burst_t    head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hts_pkg::out_beat_t out_data_o
);

  logic [2:0]         idx_q;
  logic               out_valid_q;
  hts_pkg::out_beat_t out_q;
  logic               load;
  logic               last;

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last  = (head_i.count == 3'd0) || (idx_q == 3'(head_i.count - 3'd1));
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 3'd0 : 3'(idx_q + 3'd1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte   <= (head_i.count == 3'd0) ? 8'h00 : head_i.data[idx_q];
      out_q.byte_valid <= head_i.count != 3'd0;
      out_q.run_last   <= last;
      out_q.text_end   <= last && head_i.fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> idx_q == 3'd0)
    else $error("burst index not at zero with empty queue");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i && head_i.count != 3'd0 |-> idx_q < head_i.count)
    else $error("burst index beyond burst length");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.text_end |-> out_q.run_last)
    else $error("text end without run last");

  a_marker_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.byte_valid |-> out_q.text_end)
    else $error("empty marker not at text end");

endmodule

### dv/text_beat_checker.sv
`timescale 1ns / 1ps
// text_beat_checker: follows the byte channels of html_tag_strip_entity_decode, keeps its
// own tag stripper and entity decoder, queues the beats each input beat should cause and
// compares them with the output beats; depends on hts_pkg

module text_beat_checker
  import hts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_beat_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_beat_t   out_data_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  string      entity_text [NumEnt] = '{"&amp;", "&lt;", "&gt;", "&quot;"};
  logic [7:0] entity_char [NumEnt] = '{ChAmp, ChLt, ChGt, ChQuot};

  logic       in_tag;
  logic [2:0] match_len;
  logic [3:0] cand_mask;
  logic [7:0] held [HeldDepth];

  logic [7:0]  decoded_chars [$];
  out_beat_t   expected_text [$];
  out_beat_t   want;
  int unsigned fails;

  task automatic flush_entity();
    int unsigned k;
    if (match_len != 0) begin
      decoded_chars.push_back(ChAmp);
      for (k = 0; k + 1 < match_len && k < HeldDepth; k++) decoded_chars.push_back(held[k]);
      match_len = '0;
      cand_mask = '0;
    end
  endtask

  task automatic strip_and_decode(input in_beat_t beat);
    logic [7:0]  c;
    logic [3:0]  keep;
    int unsigned pos;
    int unsigned e;
    int unsigned k;
    bit          handled;
    bit          done;
    out_beat_t   res;
    c = beat.in_byte;
    handled = 1'b0;
    done = 1'b0;
    decoded_chars.delete();
    if (match_len != 0) begin
      pos = match_len;
      keep = '0;
      for (e = 0; e < NumEnt; e++) begin
        if (cand_mask[e] && pos < entity_text[e].len() && entity_text[e][pos] == c)
          keep[e] = 1'b1;
      end
      if (keep != '0) begin
        handled = 1'b1;
        for (e = 0; e < NumEnt; e++) begin
          if (!done && keep[e] && pos + 1 == entity_text[e].len()) begin
            decoded_chars.push_back(entity_char[e]);
            match_len = '0;
            cand_mask = '0;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (pos - 1 < HeldDepth) held[pos-1] = c;
          match_len = 3'(pos + 1);
          cand_mask = keep;
        end
      end else begin
        flush_entity();
      end
    end
    if (!handled) begin
      if (c == ChLt) begin
        in_tag = 1'b1;
      end else if (c == ChGt) begin
        in_tag = 1'b0;
      end else if (!in_tag) begin
        if (c == ChAmp) begin
          match_len = 3'd1;
          cand_mask = '1;
        end else begin
          decoded_chars.push_back(c);
        end
      end
    end
    if (beat.is_final) begin
      flush_entity();
      in_tag = 1'b0;
      match_len = '0;
      cand_mask = '0;
    end
    if (decoded_chars.size() == 0) begin
      if (beat.is_final) begin
        res.out_byte = 8'h00;
        res.byte_valid = 1'b0;
        res.run_last = 1'b1;
        res.text_end = 1'b1;
        expected_text.push_back(res);
      end
    end else begin
      for (k = 0; k < decoded_chars.size(); k++) begin
        res.out_byte = decoded_chars[k];
        res.byte_valid = 1'b1;
        res.run_last = (k + 1 == decoded_chars.size());
        res.text_end = res.run_last && beat.is_final;
        expected_text.push_back(res);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag = 1'b0;
      match_len = '0;
      cand_mask = '0;
      expected_text.delete();
      fails = 0;
    end else begin
      if (in_valid_i && !in_stall_i) strip_and_decode(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected beat byte %h valid %b last %b end %b", $time,
                   out_data_i.out_byte, out_data_i.byte_valid, out_data_i.run_last,
                   out_data_i.text_end);
          fails++;
        end else begin
          want = expected_text.pop_front();
          if (out_data_i.out_byte !== want.out_byte || out_data_i.byte_valid !== want.byte_valid
              || out_data_i.run_last !== want.run_last || out_data_i.text_end !== want.text_end)
          begin
            $display("%0t: beat mismatch, expected %h %b %b %b, got %h %b %b %b",
                     $time, want.out_byte, want.byte_valid, want.run_last, want.text_end,
                     out_data_i.out_byte, out_data_i.byte_valid, out_data_i.run_last,
                     out_data_i.text_end);
            fails++;
          end
        end
      end
    end
    pending_o <= expected_text.size();
    fail_count_o <= fails;
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench: top of the html tag stripper bench; drives directed and random text
// through phases of sender and receiver idling and gives the verdict
// depends on hts_pkg, html_tag_strip_entity_decode and text_beat_checker

module testbench;
  import hts_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  string entity_text [NumEnt] = '{"&amp;", "&lt;", "&gt;", "&quot;"};

  html_tag_strip_entity_decode dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  text_beat_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input bit fin);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_data = in_beat_t'(9'($urandom_range(511)));
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data.in_byte = b;
    in_data.is_final = fin;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic send_text(input string s, input bit fin);
    int unsigned i;
    for (i = 0; i < s.len(); i++) send_beat(s[i], fin && i + 1 == s.len());
  endtask

  // well-formed entities and tags (half the chunks), some broken entities, stray '>' and raw bytes
  task automatic send_random_text(input int unsigned n_beats);
    logic [7:0]  chunk [$];
    int unsigned sent;
    int unsigned kind;
    int unsigned e;
    int unsigned len;
    int unsigned i;
    sent = 0;
    while (sent < n_beats) begin
      chunk.delete();
      kind = $urandom_range(9);
      e = $urandom_range(NumEnt - 1);
      case (kind)
        0, 1, 2: begin
          for (i = 0; i < entity_text[e].len(); i++) chunk.push_back(entity_text[e][i]);
        end
        3, 4: begin
          len = $urandom_range(entity_text[e].len() - 1, 1);
          for (i = 0; i < len; i++) chunk.push_back(entity_text[e][i]);
          chunk.push_back(8'($urandom_range(255)));
        end
        5, 6: begin
          chunk.push_back(ChLt);
          repeat ($urandom_range(4)) chunk.push_back(8'($urandom_range(255)));
          chunk.push_back(ChGt);
        end
        7: chunk.push_back(ChGt);
        default: begin
          repeat ($urandom_range(4, 1)) chunk.push_back(8'($urandom_range(255)));
        end
      endcase
      foreach (chunk[j]) send_beat(chunk[j], $urandom_range(15) == 0);
      sent += chunk.size();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_text("&quot;", 1'b0);
    // broken entity ended by a tag open
    send_text("&am<", 1'b0);
    send_text("b>", 1'b0);
    send_text(">", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    // partial entity flushed at text end
    send_text("&g", 1'b1);
    // text ending inside a tag gives the empty end marker
    send_text("<a", 1'b1);
    send_text("z", 1'b0);
    send_text("&l&gt;", 1'b1);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_text(30);
    send_idle_pct = 79;
    recv_stall_pct = 0;
    send_random_text(30);
    send_idle_pct = 0;
    recv_stall_pct = 79;
    send_random_text(30);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    send_random_text(30);

    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### html_tag_strip_entity_decode.f
rtl/core/hts_pkg.sv
rtl/core/hts_front.sv
rtl/core/hts_queue.sv
rtl/core/hts_back.sv
rtl/core/html_tag_strip_entity_decode.sv
dv/text_beat_checker.sv
dv/testbench.sv
